>>> design/urav_pkg.sv
// shared types, constants and register codes for the ultrasonic range averager
package urav_pkg;

    // parameter defaults
    localparam int SAMPLES_DEF    = 5;
    localparam int WIDTH_BITS_DEF = 16;

    // fixed field widths
    localparam int TIMER_W    = 16;
    localparam int THR_W      = 10;
    localparam int DIST_W     = 19;
    localparam int IDX_W      = 3;
    localparam int QACC_W     = DIST_W + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // echo microseconds per centimetre, and the distance ceiling
    localparam int                US_PER_CM = 58;
    localparam logic [DIST_W-1:0] DIST_MAX  = '1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_US = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_US     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_THR   = 2'd2;

    // configuration reset values
    localparam logic [TIMER_W-1:0] TRIGGER_US_RST = 16'd20;
    localparam logic [TIMER_W-1:0] GAP_US_RST     = 16'd10000;
    localparam logic [THR_W-1:0]   NEAR_THR_RST   = 10'd25;

    typedef struct packed {
        logic start_req;
        logic echo;
    } in_item_t;

    typedef struct packed {
        logic              trigger;
        logic              busy_res;
        logic              done_res;
        logic [DIST_W-1:0] distance_q8;
        logic              near;
    } out_item_t;

    typedef struct packed {
        logic [TIMER_W-1:0] trigger_us;
        logic [TIMER_W-1:0] gap_us;
        logic [THR_W-1:0]   near_threshold_cm;
    } cfg_t;

    // sequencer to accumulator controls, valid only on an advancing tick
    typedef struct packed {
        logic clear;
        logic add;
        logic publish;
    } acc_ctrl_t;

endpackage

>>> design/urav_seq.sv
// ranging sequencer: trigger, echo wait, echo count and gap timing per tick
module urav_seq #(
    parameter int SAMPLES    = urav_pkg::SAMPLES_DEF,
    parameter int WIDTH_BITS = urav_pkg::WIDTH_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                fire,
    input  urav_pkg::in_item_t  item,
    input  urav_pkg::cfg_t      cfg,
    output logic                trigger,
    output logic                busy,
    output logic                done,
    output urav_pkg::acc_ctrl_t acc_ctrl
);

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_TRIG = 3'd1,
        PH_WAIT = 3'd2,
        PH_MEAS = 3'd3,
        PH_GAP  = 3'd4
    } phase_t;

    localparam logic [WIDTH_BITS-1:0]       WIDTH_MAX = '1;
    localparam logic [urav_pkg::IDX_W-1:0] LAST_IDX  = urav_pkg::IDX_W'(SAMPLES);

    phase_t                          phase_reg, phase_next;
    logic [urav_pkg::TIMER_W-1:0]    timer_reg, timer_next;
    logic [WIDTH_BITS-1:0]           width_reg, width_next;
    logic [urav_pkg::IDX_W-1:0]      idx_reg, idx_next;
    logic [urav_pkg::TIMER_W-1:0]    timer_inc;

    assign timer_inc = timer_reg + urav_pkg::TIMER_W'(1);

    always_comb begin
        phase_next = phase_reg;
        timer_next = timer_reg;
        width_next = width_reg;
        idx_next   = idx_reg;
        trigger    = 1'b0;
        done       = 1'b0;
        acc_ctrl   = '0;
        unique case (phase_reg)
            PH_TRIG: begin
                trigger = 1'b1;
                if (timer_inc >= cfg.trigger_us || cfg.trigger_us == '0) begin
                    phase_next = PH_WAIT;
                    timer_next = '0;
                end else begin
                    timer_next = timer_inc;
                end
            end
            PH_WAIT: begin
                if (item.echo) begin
                    width_next   = WIDTH_BITS'(1);
                    phase_next   = PH_MEAS;
                    acc_ctrl.add = 1'b1;
                end
            end
            PH_MEAS: begin
                if (item.echo) begin
                    if (width_reg != WIDTH_MAX) begin
                        width_next   = width_reg + WIDTH_BITS'(1);
                        acc_ctrl.add = 1'b1;
                    end
                end else begin
                    width_next = '0;
                    idx_next   = idx_reg + urav_pkg::IDX_W'(1);
                    timer_next = '0;
                    phase_next = PH_GAP;
                    // zero gap closes the cycle on the same tick
                    if (cfg.gap_us == '0) begin
                        if (idx_next >= LAST_IDX) begin
                            phase_next       = PH_IDLE;
                            done             = 1'b1;
                            acc_ctrl.publish = 1'b1;
                        end else begin
                            phase_next = PH_TRIG;
                        end
                    end
                end
            end
            PH_GAP: begin
                if (timer_inc >= cfg.gap_us) begin
                    timer_next = '0;
                    if (idx_reg >= LAST_IDX) begin
                        phase_next       = PH_IDLE;
                        done             = 1'b1;
                        acc_ctrl.publish = 1'b1;
                    end else begin
                        phase_next = PH_TRIG;
                    end
                end else begin
                    timer_next = timer_inc;
                end
            end
            default: begin
                phase_next = PH_IDLE;
                if (item.start_req) begin
                    phase_next     = PH_TRIG;
                    timer_next     = '0;
                    width_next     = '0;
                    idx_next       = '0;
                    acc_ctrl.clear = 1'b1;
                end
            end
        endcase
    end

    assign busy = (phase_next != PH_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            timer_reg <= '0;
            width_reg <= '0;
            idx_reg   <= '0;
        end else if (fire) begin
            phase_reg <= phase_next;
            timer_reg <= timer_next;
            width_reg <= width_next;
            idx_reg   <= idx_next;
        end
    end

    a_idle_no_count: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_IDLE |-> timer_reg == '0 && width_reg == '0)
        else $error("idle phase with live timer or echo count");

    a_trig_timer_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_TRIG && cfg.trigger_us != '0 |-> timer_reg < cfg.trigger_us)
        else $error("trigger timer ran past pulse length");

    a_index_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg <= LAST_IDX)
        else $error("sample index beyond burst length");

endmodule

>>> design/urav_acc.sv
// running quotient of echo sum * 256 / (58 * samples), published distance and near flag
module urav_acc #(
    parameter int SAMPLES = urav_pkg::SAMPLES_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               fire,
    input  urav_pkg::acc_ctrl_t                acc_ctrl,
    input  logic [urav_pkg::THR_W-1:0]         near_threshold_cm,
    output logic [urav_pkg::DIST_W-1:0]        distance_q8,
    output logic                               near
);

    // each counted echo tick adds 256 to the numerator: whole part and remainder
    localparam int Divisor = urav_pkg::US_PER_CM * SAMPLES;
    localparam int IncQ    = 256 / Divisor;
    localparam int IncR    = 256 % Divisor;
    localparam int RemW    = $clog2(2 * Divisor);
    localparam int QW      = urav_pkg::QACC_W;
    localparam int DW      = urav_pkg::DIST_W;

    logic [QW-1:0]   q_reg, q_next, q_add;
    logic [RemW-1:0] r_reg, r_next, r_sum;
    logic            carry;
    logic [DW-1:0]   dist_reg, dist_new;
    logic            near_reg, near_new;

    assign r_sum  = r_reg + RemW'(IncR);
    assign carry  = (r_sum >= RemW'(Divisor));
    assign q_add  = q_reg + QW'(IncQ) + QW'(carry);

    always_comb begin
        q_next = q_reg;
        r_next = r_reg;
        if (acc_ctrl.clear) begin
            q_next = '0;
            r_next = '0;
        end else if (acc_ctrl.add) begin
            r_next = carry ? r_sum - RemW'(Divisor) : r_sum;
            // quotient only grows, so clamping here equals clamping the result
            q_next = (q_add > QW'(urav_pkg::DIST_MAX)) ? QW'(urav_pkg::DIST_MAX) : q_add;
        end
    end

    assign dist_new = q_reg[DW-1:0];
    assign near_new = (dist_new[DW-1:8] < {1'b0, near_threshold_cm});

    assign distance_q8 = acc_ctrl.publish ? dist_new : dist_reg;
    assign near        = acc_ctrl.publish ? near_new : near_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg    <= '0;
            r_reg    <= '0;
            dist_reg <= '0;
            near_reg <= 1'b0;
        end else if (fire) begin
            q_reg <= q_next;
            r_reg <= r_next;
            if (acc_ctrl.publish) begin
                dist_reg <= dist_new;
                near_reg <= near_new;
            end
        end
    end

    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        r_reg < RemW'(Divisor))
        else $error("remainder reached divisor");

    a_quot_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_reg <= QW'(urav_pkg::DIST_MAX))
        else $error("quotient above distance ceiling");

    a_ctrl_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |-> $countones({acc_ctrl.clear, acc_ctrl.add, acc_ctrl.publish}) <= 1)
        else $error("accumulator controls overlap");

endmodule

>>> design/ultrasonic_range_averager_unit.sv
// top level of the ultrasonic range averager: config registers, input and result stages
//
// usage
// - s_ channel: one transfer per microsecond tick, carrying start_req and the
//   sampled echo level; m_ channel: exactly one result transfer per tick with
//   the trigger level, busy/done flags, last mean distance (1/256 cm) and near
// - cfg channel: writes trigger_us, gap_us, near_threshold_cm by index; always
//   ready, meant to be used while no tick is in flight; unknown indexes ignored
// - a start_req while idle begins a burst of SAMPLES ranging cycles; done_res
//   pulses on the tick the new average is published
// - path: a tick is held in the input register while the sequencer and running
//   quotient compute its result, which is then captured in the result register
// - throughput: one tick per cycle unless m_ready stalls the result register;
//   the input register and the result register each hold one item, and the
//   sequencer plus running quotient update is combinational between them
// - the mean is kept as a running quotient with remainder, one compare and
//   subtract per counted echo tick, so publishing needs no divider
// - stall: when m_ready is low and a result is held, the result register holds
//   and s_ready is low whenever the input register is full; no tick is lost or repeated
// - reset (aresetn low, synchronous): both stages empty, sequencer idle, sums
//   and the published distance cleared, config back to 20 / 10000 / 25
module ultrasonic_range_averager_unit #(
    parameter int SAMPLES    = urav_pkg::SAMPLES_DEF,
    parameter int WIDTH_BITS = urav_pkg::WIDTH_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  urav_pkg::in_item_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output urav_pkg::out_item_t                 m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [urav_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [urav_pkg::CFG_DATA_W-1:0]     cfg_data
);

    urav_pkg::cfg_t      cfg_reg;
    urav_pkg::in_item_t  in_item_reg;
    logic                in_valid_reg;
    urav_pkg::out_item_t m_data_reg;
    logic                m_valid_reg;

    logic                advance;
    logic                fire;
    logic                seq_trigger;
    logic                seq_busy;
    logic                seq_done;
    urav_pkg::acc_ctrl_t acc_ctrl;
    logic [urav_pkg::DIST_W-1:0] acc_distance;
    logic                acc_near;

    // config writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.trigger_us        <= urav_pkg::TRIGGER_US_RST;
            cfg_reg.gap_us            <= urav_pkg::GAP_US_RST;
            cfg_reg.near_threshold_cm <= urav_pkg::NEAR_THR_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                urav_pkg::CFG_TRIGGER_US: cfg_reg.trigger_us <= cfg_data;
                urav_pkg::CFG_GAP_US:     cfg_reg.gap_us     <= cfg_data;
                urav_pkg::CFG_NEAR_THR:
                    cfg_reg.near_threshold_cm <= cfg_data[urav_pkg::THR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // stage handshake: result slot free or draining this cycle
    assign advance = !m_valid_reg || m_ready;
    assign fire    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    // input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
    end

    urav_seq #(
        .SAMPLES    (SAMPLES),
        .WIDTH_BITS (WIDTH_BITS)
    ) u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .fire     (fire),
        .item     (in_item_reg),
        .cfg      (cfg_reg),
        .trigger  (seq_trigger),
        .busy     (seq_busy),
        .done     (seq_done),
        .acc_ctrl (acc_ctrl)
    );

    urav_acc #(
        .SAMPLES (SAMPLES)
    ) u_acc (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .fire              (fire),
        .acc_ctrl          (acc_ctrl),
        .near_threshold_cm (cfg_reg.near_threshold_cm),
        .distance_q8       (acc_distance),
        .near              (acc_near)
    );

    // result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_data_reg.trigger     <= seq_trigger;
            m_data_reg.busy_res    <= seq_busy;
            m_data_reg.done_res    <= seq_done;
            m_data_reg.distance_q8 <= acc_distance;
            m_data_reg.near        <= acc_near;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg.done_res |-> !m_data_reg.busy_res)
        else $error("done reported while still busy");

    a_trigger_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg.trigger |-> m_data_reg.busy_res)
        else $error("trigger driven outside a burst");

    a_input_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_item_reg))
        else $error("input stage changed while result stalled");

endmodule
